// ----- design/sha256_hash_engine_macros.svh -----
// Assertion helpers shared by the hash engine modules.
`ifndef SHA256_HASH_ENGINE_MACROS_SVH
`define SHA256_HASH_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha256 engine check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha256 engine check failed");

`endif

// ----- design/sha_pkg.sv -----
package sha_pkg;

  localparam int MSG_WORDS   = 16;
  localparam int CHAIN_WORDS = 8;
  localparam int ROUNDS      = 64;
  localparam int MSG_AW      = $clog2(MSG_WORDS);
  localparam int CHAIN_AW    = $clog2(CHAIN_WORDS);

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic                start;
    logic                dig_rd;
    logic [CHAIN_AW-1:0] dig_addr;
    logic                chain_clear;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_s0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_s0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t ch_fn(input word_t x, input word_t y, input word_t z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic word_t maj_fn(input word_t x, input word_t y, input word_t z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

  function automatic word_t iv_word(input logic [CHAIN_AW-1:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// ----- design/sha_ram.sv -----
module sha_ram
  import sha_pkg::*;
#(
  parameter int  DEPTH = MSG_WORDS,
  parameter int  WIDTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/sha_core.sv -----
`include "sha256_hash_engine_macros.svh"

module sha_core
  import sha_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  core_ctrl_t        ctrl,
  output core_stat_t        stat,
  output logic              msg_rd_en,
  output logic [MSG_AW-1:0] msg_rd_addr,
  input  word_t             msg_rd_data,
  output word_t             dig_data
);

  localparam logic [1:0] CS_IDLE  = 2'd0;
  localparam logic [1:0] CS_LOAD  = 2'd1;
  localparam logic [1:0] CS_ROUND = 2'd2;
  localparam logic [1:0] CS_FOLD  = 2'd3;

  localparam logic [3:0] LAST_CNT = 4'(CHAIN_WORDS);
  localparam logic [5:0] LAST_RND = 6'(ROUNDS - 1);

  logic [1:0] state;
  logic [3:0] cnt;
  logic [3:0] cnt_m1;
  logic [5:0] rnd;

  word_t v [CHAIN_WORDS];
  word_t w [MSG_WORDS];

  logic [CHAIN_WORDS-1:0] valid;
  logic                   rd_valid;
  logic [CHAIN_AW-1:0]    rd_addr_q;

  logic                c_rd_en;
  logic [CHAIN_AW-1:0] c_rd_addr;
  word_t               c_rd_q;
  logic                c_wr_en;
  logic [CHAIN_AW-1:0] c_wr_addr;
  word_t               c_wr_data;

  word_t chain_data;
  word_t w_cur;
  word_t t1;
  word_t t2;

  sha_ram #(
    .DEPTH(CHAIN_WORDS),
    .WIDTH(32)
  ) u_chain_ram (
    .clk    (clk),
    .wr_en  (c_wr_en),
    .wr_addr(c_wr_addr),
    .wr_data(c_wr_data),
    .rd_en  (c_rd_en),
    .rd_addr(c_rd_addr),
    .rd_data(c_rd_q)
  );

  // An entry not written since reset or the last digest reads as the initial hash.
  assign chain_data = rd_valid ? c_rd_q : iv_word(rd_addr_q);
  assign dig_data   = chain_data;
  assign cnt_m1     = cnt - 4'd1;

  always_comb begin
    if (state == CS_IDLE) begin
      c_rd_en   = ctrl.dig_rd;
      c_rd_addr = ctrl.dig_addr;
    end else begin
      c_rd_en   = (state == CS_LOAD || state == CS_FOLD) && !cnt[3];
      c_rd_addr = cnt[CHAIN_AW-1:0];
    end
  end

  assign msg_rd_en   = (state == CS_LOAD && cnt == LAST_CNT) ||
                       (state == CS_ROUND && rnd < 6'(MSG_WORDS - 1));
  assign msg_rd_addr = (state == CS_LOAD) ? '0 : rnd[MSG_AW-1:0] + MSG_AW'(1);

  assign w_cur = (rnd < 6'(MSG_WORDS)) ? msg_rd_data :
                 small_s1(w[MSG_WORDS-2]) + w[MSG_WORDS-7] + small_s0(w[1]) + w[0];
  assign t1 = v[7] + big_s1(v[4]) + ch_fn(v[4], v[5], v[6]) + round_k(rnd) + w_cur;
  assign t2 = big_s0(v[0]) + maj_fn(v[0], v[1], v[2]);

  assign c_wr_en   = (state == CS_FOLD) && (cnt != 4'd0);
  assign c_wr_addr = cnt_m1[CHAIN_AW-1:0];
  assign c_wr_data = chain_data + v[0];

  assign stat.busy = (state != CS_IDLE);
  assign stat.done = (state == CS_FOLD) && (cnt == LAST_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      cnt   <= '0;
      rnd   <= '0;
      valid <= '0;
    end else begin
      if (ctrl.chain_clear) begin
        valid <= '0;
      end else if (c_wr_en) begin
        valid[c_wr_addr] <= 1'b1;
      end
      unique case (state)
        CS_IDLE: begin
          if (ctrl.start) begin
            state <= CS_LOAD;
            cnt   <= '0;
          end
        end
        CS_LOAD: begin
          if (cnt == LAST_CNT) begin
            state <= CS_ROUND;
            rnd   <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        CS_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == LAST_RND) begin
            state <= CS_FOLD;
            cnt   <= '0;
          end
        end
        CS_FOLD: begin
          if (cnt == LAST_CNT) begin
            state <= CS_IDLE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        default: state <= CS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_valid  <= valid[c_rd_addr];
    rd_addr_q <= c_rd_addr;
    if ((state == CS_LOAD || state == CS_FOLD) && cnt != 4'd0) begin
      // Load shifts chain words in from the top; fold rotates so v[0] meets its entry.
      for (int i = 0; i < CHAIN_WORDS - 1; i++) begin
        v[i] <= v[i+1];
      end
      v[CHAIN_WORDS-1] <= (state == CS_LOAD) ? chain_data : v[0];
    end else if (state == CS_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int i = 0; i < MSG_WORDS - 1; i++) begin
        w[i] <= w[i+1];
      end
      w[MSG_WORDS-1] <= w_cur;
    end
  end

  `ASSERT_IMPL(a_start_idle, ctrl.start, state == CS_IDLE)
  `ASSERT_IMPL(a_dig_idle, ctrl.dig_rd, state == CS_IDLE)
  `ASSERT_NEXT(a_round_to_fold, state == CS_ROUND && rnd == LAST_RND, state == CS_FOLD)

endmodule

// ----- design/sha256_hash_engine.sv -----
// SHA-256 engine taking one message byte per input transaction: tdata[7:0] is the
// byte, tuser marks it as part of the message, and tlast ends the message (tlast
// with tuser low pads the message as it stands, so an empty message is legal). Each
// 64-byte block is stored word by word in a 16-entry message memory; once full, the
// input stalls while the round unit loads the eight chaining words from their
// memory, runs 64 rounds at one per cycle and folds the result back. On tlast the
// padding and 64-bit bit length are written one word per cycle, with a compression
// after each filled block (one or two compressions), then eight digest words leave
// on the master side, word 0 first, each fetched only after the one before it is
// taken, with tlast on word 7. After the last word the engine is back in its
// initial hash state.
`include "sha256_hash_engine_macros.svh"

module sha256_hash_engine
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero above
  output logic        m_tlast
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CWAIT  = 3'd1;
  localparam logic [2:0] ST_PFIRST = 3'd2;
  localparam logic [2:0] ST_PFILL  = 3'd3;
  localparam logic [2:0] ST_OREQ   = 3'd4;
  localparam logic [2:0] ST_OCAP   = 3'd5;
  localparam logic [2:0] ST_OWAIT  = 3'd6;

  localparam logic [1:0] CONT_IDLE = 2'd0;
  localparam logic [1:0] CONT_PAD  = 2'd1;
  localparam logic [1:0] CONT_FILL = 2'd2;
  localparam logic [1:0] CONT_OUT  = 2'd3;

  localparam logic [MSG_AW-1:0]   LAST_WORD  = MSG_AW'(MSG_WORDS - 1);
  localparam logic [MSG_AW-1:0]   LEN_HI     = MSG_AW'(MSG_WORDS - 2);
  localparam logic [CHAIN_AW-1:0] LAST_DIG   = CHAIN_AW'(CHAIN_WORDS - 1);

  logic [2:0]          state;
  logic [1:0]          cont;
  logic [63:0]         message_bits;
  word_t               wbuf;
  logic [MSG_AW-1:0]   widx;
  logic                extra;
  logic [CHAIN_AW-1:0] oidx;
  word_t               out_word;
  logic [CHAIN_AW-1:0] out_index;
  logic                out_last;

  logic                accept;
  logic [5:0]          pos;
  word_t               byte_word;
  word_t               pad_word;
  word_t               fill_word;
  logic                mw_en;
  logic [MSG_AW-1:0]   mw_addr;
  word_t               mw_data;
  logic                mr_en;
  logic [MSG_AW-1:0]   mr_addr;
  word_t               mr_data;
  word_t               dig_data;
  core_ctrl_t          ctrl;
  core_stat_t          stat;

  sha_ram #(
    .DEPTH(MSG_WORDS),
    .WIDTH(32)
  ) u_msg_ram (
    .clk    (clk),
    .wr_en  (mw_en),
    .wr_addr(mw_addr),
    .wr_data(mw_data),
    .rd_en  (mr_en),
    .rd_addr(mr_addr),
    .rd_data(mr_data)
  );

  sha_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .msg_rd_en  (mr_en),
    .msg_rd_addr(mr_addr),
    .msg_rd_data(mr_data),
    .dig_data   (dig_data)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign pos      = message_bits[8:3];

  // Byte 0 of a word is its most significant byte.
  always_comb begin
    byte_word = wbuf;
    pad_word  = '0;
    for (int j = 0; j < 4; j++) begin
      if (2'(j) == pos[1:0]) begin
        byte_word[31-8*j -: 8] = s_tdata;
        pad_word[31-8*j -: 8]  = PAD_BYTE;
      end else if (2'(j) < pos[1:0]) begin
        pad_word[31-8*j -: 8] = wbuf[31-8*j -: 8];
      end
    end
  end

  always_comb begin
    fill_word = '0;
    if (!extra && widx == LEN_HI) begin
      fill_word = message_bits[63:32];
    end else if (!extra && widx == LAST_WORD) begin
      fill_word = message_bits[31:0];
    end
  end

  always_comb begin
    mw_en   = 1'b0;
    mw_addr = pos[5:2];
    mw_data = byte_word;
    unique case (state)
      ST_IDLE:   mw_en = accept && s_tuser && (pos[1:0] == 2'd3);
      ST_PFIRST: begin
        mw_en   = 1'b1;
        mw_data = pad_word;
      end
      ST_PFILL: begin
        mw_en   = 1'b1;
        mw_addr = widx;
        mw_data = fill_word;
      end
      default: mw_en = 1'b0;
    endcase
  end

  assign ctrl.start = (state == ST_IDLE && accept && s_tuser && pos == 6'd63) ||
                      (state == ST_PFIRST && pos[5:2] == LAST_WORD) ||
                      (state == ST_PFILL && widx == LAST_WORD);
  assign ctrl.dig_rd      = (state == ST_OREQ);
  assign ctrl.dig_addr    = oidx;
  assign ctrl.chain_clear = (state == ST_OWAIT) && m_tready && (oidx == LAST_DIG);

  assign m_tdata = {5'd0, out_index, out_word};
  assign m_tlast = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cont         <= CONT_IDLE;
      message_bits <= '0;
      widx         <= '0;
      extra        <= 1'b0;
      oidx         <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              message_bits <= message_bits + 64'd8;
            end
            if (s_tuser && pos == 6'd63) begin
              state <= ST_CWAIT;
              cont  <= s_tlast ? CONT_PAD : CONT_IDLE;
            end else if (s_tlast) begin
              state <= ST_PFIRST;
            end
          end
        end
        ST_CWAIT: begin
          if (stat.done) begin
            case (cont)
              CONT_IDLE: state <= ST_IDLE;
              CONT_PAD:  state <= ST_PFIRST;
              CONT_FILL: begin
                state <= ST_PFILL;
                widx  <= '0;
                extra <= 1'b0;
              end
              default: begin
                state <= ST_OREQ;
                oidx  <= '0;
              end
            endcase
          end
        end
        ST_PFIRST: begin
          // Pad byte at or past byte 56 leaves no room for the length here.
          extra <= (pos[5:3] == 3'b111);
          if (pos[5:2] == LAST_WORD) begin
            state <= ST_CWAIT;
            cont  <= CONT_FILL;
          end else begin
            widx  <= pos[5:2] + MSG_AW'(1);
            state <= ST_PFILL;
          end
        end
        ST_PFILL: begin
          widx <= widx + MSG_AW'(1);
          if (widx == LAST_WORD) begin
            state <= ST_CWAIT;
            cont  <= extra ? CONT_FILL : CONT_OUT;
          end
        end
        ST_OREQ: state <= ST_OCAP;
        ST_OCAP: begin
          m_tvalid <= 1'b1;
          state    <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (oidx == LAST_DIG) begin
              message_bits <= '0;
              state        <= ST_IDLE;
            end else begin
              oidx  <= oidx + CHAIN_AW'(1);
              state <= ST_OREQ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser) begin
      wbuf <= byte_word;
    end
    if (state == ST_OCAP) begin
      out_word  <= dig_data;
      out_index <= oidx;
      out_last  <= (oidx == LAST_DIG);
    end
  end

  `ASSERT_IMPL(a_out_in_wait, m_tvalid, state == ST_OWAIT)
  `ASSERT_IMPL(a_no_intake_busy, s_tready, !stat.busy)
  `ASSERT_NEXT(a_len_cleared, m_tvalid && m_tready && m_tlast, message_bits == '0 && state == ST_IDLE)

endmodule

// ----- tb/tb_sha256_hash_engine.sv -----
`timescale 1ns / 100ps

module tb_sha256_hash_engine;
  import sha_pkg::word_t;
  import sha_pkg::PAD_BYTE;

  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_LIMIT = 50000;
  localparam int SETTLE_CYCLES = 250;

  localparam int SEND_PCT [3] = '{17, 73, 0};
  localparam int RECV_PCT [3] = '{73, 17, 0};
  // message lengths around the padding boundary, one per phase
  localparam int EDGE_LEN [3] = '{56, 55, 64};

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         last;
    logic         known;
    logic [255:0] digest;
  } byte_row_t;

  typedef struct {
    word_t      word;
    logic [2:0] index;
    logic       is_tail;
  } digest_word_t;

  localparam int NUM_ROWS = 12;
  byte_row_t byte_rows [NUM_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},        // no byte, not last: ignored
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // byte with last
    '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // back to initial state
    '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'ha5, 1'b0, 1'b1, 1'b0, 256'h0}         // last with no byte
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tuser = 1'b0;    // [0] byte_present
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [31:0] digest_word, [34:32] word_index, zero above
  logic        m_tlast;

  // hash model state
  word_t       chain [8];
  logic [7:0]  block_buf [64];
  word_t       sched [16];
  logic [63:0] msg_bits;

  digest_word_t digest_q [$];

  int send_pct = 17;
  int recv_pct = 73;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int hold_cnt = 0;
  int errors = 0;
  int bytes_sent = 0;
  int messages = 0;
  int words_checked = 0;

  sha256_hash_engine uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    word_t v [8];
    word_t w, t1, t2, a2, a15;
    int r, j;
    for (j = 0; j < 8; j++) v[j] = chain[j];
    for (r = 0; r < 64; r++) begin
      if (r < 16) begin
        w = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
      end else begin
        a2 = sched[(r - 2) & 15];
        a15 = sched[(r - 15) & 15];
        w = (ror(a2, 17) ^ ror(a2, 19) ^ (a2 >> 10)) + sched[(r - 7) & 15] +
            (ror(a15, 7) ^ ror(a15, 18) ^ (a15 >> 3)) + sched[r & 15];
      end
      sched[r & 15] = w;
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (j = 0; j < 8; j++) chain[j] = chain[j] + v[j];
  endfunction

  function automatic void reset_hash();
    int j;
    for (j = 0; j < 8; j++) chain[j] = HASH_IV[j];
    for (j = 0; j < 64; j++) block_buf[j] = 8'h00;
    for (j = 0; j < 16; j++) sched[j] = '0;
    msg_bits = '0;
  endfunction

  // Fold one accepted byte transaction into the hash; on last, pad and queue the digest.
  function automatic void absorb_byte(input logic [7:0] b, input logic present,
                                      input logic last, input logic known,
                                      input logic [255:0] dg);
    int pos, j;
    digest_word_t e;
    if (present) begin
      pos = int'(msg_bits[8:3]);
      block_buf[pos] = b;
      msg_bits = msg_bits + 64'd8;
      if (pos == 63) compress_block();
    end
    if (!last) return;
    pos = int'(msg_bits[8:3]);
    block_buf[pos] = PAD_BYTE;
    pos = pos + 1;
    if (pos > 56) begin
      while (pos < 64) begin
        block_buf[pos] = 8'h00;
        pos = pos + 1;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      block_buf[pos] = 8'h00;
      pos = pos + 1;
    end
    for (j = 0; j < 8; j++) block_buf[56 + j] = msg_bits[63 - 8*j -: 8];
    compress_block();
    for (j = 0; j < 8; j++) begin
      e.word = known ? dg[255 - 32*j -: 32] : chain[j];
      e.index = 3'(j);
      e.is_tail = (j == 7);
      digest_q.push_back(e);
    end
    for (j = 0; j < 8; j++) chain[j] = HASH_IV[j];
    msg_bits = '0;
    messages++;
  endfunction

  task automatic offer_byte(input logic [7:0] b, input logic present, input logic last,
                            input logic known, input logic [255:0] dg);
    while ($urandom_range(99) < send_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= present;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    absorb_byte(b, present, last, known, dg);
    if (present) bytes_sent++;
  endtask

  task automatic send_message(input int len, input logic separate_last);
    int i;
    for (i = 0; i < len; i++) begin
      // sprinkle in transactions the engine should ignore
      if ($urandom_range(19) == 0) offer_byte(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
      offer_byte(8'($urandom), 1'b1, (i == len - 1) && !separate_last, 1'b0, '0);
    end
    if (len == 0 || separate_last) offer_byte(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cnt <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    digest_word_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest transaction, expected none, got tdata=%h tlast=%b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        e = digest_q.pop_front();
        words_checked++;
        if (m_tdata[31:0] !== e.word) begin
          $display("%0t: digest_word expected %h got %h", $time, e.word, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[34:32] !== e.index) begin
          $display("%0t: word_index expected %0d got %0d", $time, e.index, m_tdata[34:32]);
          errors++;
        end
        if (m_tdata[39:35] !== 5'd0) begin
          $display("%0t: tdata padding expected 0 got %h", $time, m_tdata[39:35]);
          errors++;
        end
        if (m_tlast !== e.is_tail) begin
          $display("%0t: last_word expected %b got %b", $time, e.is_tail, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    int r, ph;
    reset_hash();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < NUM_ROWS; r++) begin
      offer_byte(byte_rows[r].data, byte_rows[r].present, byte_rows[r].last,
                 byte_rows[r].known, byte_rows[r].digest);
    end
    wait_drain();

    for (ph = 0; ph < 3; ph++) begin
      send_pct = SEND_PCT[ph];
      recv_pct <= RECV_PCT[ph];
      // stall the output long enough that the engine backs up into its input
      if (ph == 2) hold_req <= ~hold_req;
      send_message(EDGE_LEN[ph], 1'($urandom_range(1)));
      send_message($urandom_range(4, 1), 1'($urandom_range(1)));
      wait_drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (digest_q.size() != 0) begin
      $display("%0t: %0d digest words still expected, got none", $time, digest_q.size());
      errors++;
    end
    $display("tb: hashed %0d messages from %0d bytes, incl. 55/56/64-byte padding edges",
             messages, bytes_sent);
    $display("tb: %0d digest words checked under mixed backpressure", words_checked);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/sha_pkg.sv
design/sha_ram.sv
design/sha_core.sv
design/sha256_hash_engine.sv
tb/tb_sha256_hash_engine.sv
